/* rtl/tdmpd_pkg.sv */
// Package for the timed dual motor PWM drive.
// Holds codes, the configuration record and the small lookup functions.
// Depends on nothing.
`timescale 1ns / 1ps

package tdmpd_pkg;

  localparam int PWM_PERIOD_DEF = 101;
  localparam int LINE_BITS_DEF  = 10;
  localparam int LINE_RESET     = 700;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int CNT_W      = 7;
  localparam int DUR_W      = 16;
  localparam int SPD_W      = 5;

  // Reciprocal of ten, exact for dividends below 2**22 after a shift by 23.
  localparam logic [19:0] DIV10_MUL   = 20'd838861;
  localparam int          DIV10_SHIFT = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MAX = 3'd5;

  localparam logic [1:0] KIND_PWM  = 2'd0;
  localparam logic [1:0] KIND_TIME = 2'd1;
  localparam logic [1:0] KIND_MOVE = 2'd2;
  localparam logic [1:0] KIND_NOP  = 2'd3;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BWD  = 2'd2;

  localparam logic [1:0] CAUSE_NONE   = 2'd0;
  localparam logic [1:0] CAUSE_TIME   = 2'd1;
  localparam logic [1:0] CAUSE_SENSOR = 2'd2;

  typedef struct packed {
    logic                  suppress_abort;
    logic [5:0]            abort_enable_mask;
    logic [CFG_DATA_W-1:0] left_line_min;
    logic [CFG_DATA_W-1:0] left_line_max;
    logic [CFG_DATA_W-1:0] right_line_min;
    logic [CFG_DATA_W-1:0] right_line_max;
  } cfg_t;

  function automatic logic [1:0] dir_of(logic [SPD_W-1:0] spd);
    logic [1:0] d;
    if (spd == '0) begin
      d = DIR_STOP;
    end else if (spd[SPD_W-1]) begin
      d = DIR_BWD;
    end else begin
      d = DIR_FWD;
    end
    return d;
  endfunction

  // Magnitude of a speed level, clamped to ten.
  function automatic logic [3:0] level_of(logic [SPD_W-1:0] spd);
    logic [SPD_W-1:0] mag;
    logic [3:0]       lvl;
    mag = spd[SPD_W-1] ? SPD_W'(6'd32 - {1'b0, spd}) : spd;
    lvl = (mag > 5'd10) ? 4'd10 : mag[3:0];
    return lvl;
  endfunction

  function automatic logic [CNT_W-1:0] duty_lut(logic [3:0] lvl);
    logic [CNT_W-1:0] duty;
    case (lvl)
      4'd1:    duty = 7'd12;
      4'd2:    duty = 7'd20;
      4'd3:    duty = 7'd30;
      4'd4:    duty = 7'd40;
      4'd5:    duty = 7'd50;
      4'd6:    duty = 7'd60;
      4'd7:    duty = 7'd70;
      4'd8:    duty = 7'd80;
      4'd9:    duty = 7'd90;
      4'd10:   duty = 7'd100;
      default: duty = 7'd0;
    endcase
    return duty;
  endfunction

  // Pins of one channel: bit 0 enable, bit 1 forward, bit 2 backward.
  function automatic logic [2:0] chan_pins(logic [2:0] old, logic [CNT_W-1:0] cnt,
                                           logic [CNT_W-1:0] duty, logic [1:0] dir);
    logic [2:0] pins;
    if (cnt > duty) begin
      pins = old & 3'b110;
    end else if (dir == DIR_FWD) begin
      pins = 3'b011;
    end else if (dir == DIR_BWD) begin
      pins = 3'b101;
    end else begin
      pins = 3'b001;
    end
    return pins;
  endfunction

endpackage

/* rtl/tdmpd_if.sv */
// Handshake interfaces of the timed dual motor PWM drive: command, result
// and configuration channels. Depends on tdmpd_pkg.
`timescale 1ns / 1ps

interface tdmpd_cmd_if #(
  parameter int LINE_BITS = tdmpd_pkg::LINE_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic                              left_ir;
  logic                              right_ir;
  logic                              left_bump;
  logic                              right_bump;
  logic [LINE_BITS-1:0]              left_adc;
  logic [LINE_BITS-1:0]              right_adc;
  logic [tdmpd_pkg::DUR_W-1:0]       duration;
  logic signed [tdmpd_pkg::SPD_W-1:0] left_speed;
  logic signed [tdmpd_pkg::SPD_W-1:0] right_speed;

  modport source (
    output valid, kind, left_ir, right_ir, left_bump, right_bump,
           left_adc, right_adc, duration, left_speed, right_speed,
    input  ready
  );
  modport sink (
    input  valid, kind, left_ir, right_ir, left_bump, right_bump,
           left_adc, right_adc, duration, left_speed, right_speed,
    output ready
  );
endinterface

interface tdmpd_res_if;
  logic       valid;
  logic       ready;
  logic       left_enable;
  logic       left_forward;
  logic       left_backward;
  logic       right_enable;
  logic       right_forward;
  logic       right_backward;
  logic       busy_res;
  logic [1:0] end_cause;

  modport source (
    output valid, left_enable, left_forward, left_backward, right_enable,
           right_forward, right_backward, busy_res, end_cause,
    input  ready
  );
  modport sink (
    input  valid, left_enable, left_forward, left_backward, right_enable,
           right_forward, right_backward, busy_res, end_cause,
    output ready
  );
endinterface

interface tdmpd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tdmpd_pkg::CFG_IDX_W-1:0]  index;
  logic [tdmpd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/tdmpd_cfg_regs.sv */
// Configuration register file of the timed dual motor PWM drive.
// Depends on tdmpd_pkg and tdmpd_cfg_if.
`timescale 1ns / 1ps

module tdmpd_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  tdmpd_cfg_if.sink       cfg_i,
  output tdmpd_pkg::cfg_t cfg_o
);

  tdmpd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        tdmpd_pkg::CFG_SUPPRESS:  cfg_d.suppress_abort    = cfg_i.data[0];
        tdmpd_pkg::CFG_MASK:      cfg_d.abort_enable_mask = cfg_i.data[5:0];
        tdmpd_pkg::CFG_LEFT_MIN:  cfg_d.left_line_min     = cfg_i.data;
        tdmpd_pkg::CFG_LEFT_MAX:  cfg_d.left_line_max     = cfg_i.data;
        tdmpd_pkg::CFG_RIGHT_MIN: cfg_d.right_line_min    = cfg_i.data;
        tdmpd_pkg::CFG_RIGHT_MAX: cfg_d.right_line_max    = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.suppress_abort    <= 1'b0;
      cfg_q.abort_enable_mask <= '0;
      cfg_q.left_line_min     <= '0;
      cfg_q.left_line_max     <= '1;
      cfg_q.right_line_min    <= '0;
      cfg_q.right_line_max    <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/tdmpd_sense.sv */
// Sensor latches and the sensor stop condition of the timed dual motor
// PWM drive. Depends on tdmpd_pkg.
`timescale 1ns / 1ps

module tdmpd_sense #(
  parameter int LINE_BITS = tdmpd_pkg::LINE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [3:0]           switch_i,
  input  logic [LINE_BITS-1:0] left_line_i,
  input  logic [LINE_BITS-1:0] right_line_i,
  input  tdmpd_pkg::cfg_t      cfg_i,
  output logic                 hit_o
);

  localparam int CMP_W = (LINE_BITS > tdmpd_pkg::CFG_DATA_W) ?
                         LINE_BITS : tdmpd_pkg::CFG_DATA_W;

  logic [3:0]           switch_q, switch_d;
  logic [LINE_BITS-1:0] left_q, left_d;
  logic [LINE_BITS-1:0] right_q, right_d;
  logic [CMP_W-1:0]     left_x, right_x;
  logic                 left_in, right_in;
  logic [5:0]           cond;

  assign switch_d = load_i ? switch_i : switch_q;
  assign left_d   = load_i ? left_line_i : left_q;
  assign right_d  = load_i ? right_line_i : right_q;

  // The check of an item sees the samples that the same item latches.
  assign left_x   = CMP_W'(left_d);
  assign right_x  = CMP_W'(right_d);
  assign left_in  = (left_x >= CMP_W'(cfg_i.left_line_min)) &&
                    (left_x <= CMP_W'(cfg_i.left_line_max));
  assign right_in = (right_x >= CMP_W'(cfg_i.right_line_min)) &&
                    (right_x <= CMP_W'(cfg_i.right_line_max));

  assign cond  = {right_in, left_in, switch_d[3], switch_d[2], ~switch_d[1], ~switch_d[0]};
  assign hit_o = |(cond & cfg_i.abort_enable_mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      switch_q <= '0;
      left_q   <= LINE_BITS'(tdmpd_pkg::LINE_RESET);
      right_q  <= LINE_BITS'(tdmpd_pkg::LINE_RESET);
    end else begin
      switch_q <= switch_d;
      left_q   <= left_d;
      right_q  <= right_d;
    end
  end

endmodule

/* rtl/tdmpd_core.sv */
// Input register, move and PWM state update and result register of the
// timed dual motor PWM drive. Depends on tdmpd_pkg, the interfaces and tdmpd_sense.
`timescale 1ns / 1ps

module tdmpd_core #(
  parameter int PWM_PERIOD = tdmpd_pkg::PWM_PERIOD_DEF,
  parameter int LINE_BITS  = tdmpd_pkg::LINE_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tdmpd_pkg::cfg_t cfg_i,
  tdmpd_cmd_if.sink       cmd_i,
  tdmpd_res_if.source     res_o
);

  localparam int CW = tdmpd_pkg::CNT_W;
  localparam int DW = tdmpd_pkg::DUR_W;
  localparam int SW = tdmpd_pkg::SPD_W;
  localparam logic [CW-1:0] PERIOD = CW'(PWM_PERIOD);

  // Input register.
  logic                 in_vld_q;
  logic [1:0]           kind_q;
  logic [3:0]           sw_q;
  logic [LINE_BITS-1:0] lline_q, rline_q;
  logic [DW-1:0]        dur_q;
  logic [SW-1:0]        lspd_q, rspd_q;

  // Drive state.
  logic [CW-1:0] pwm_cnt_q, pwm_cnt_d;
  logic [CW-1:0] lduty_q, lduty_d, rduty_q, rduty_d;
  logic [1:0]    ldir_q, ldir_d, rdir_q, rdir_d;
  logic [DW-1:0] tick_q, tick_d, limit_q, limit_d;
  logic          moving_q, moving_d;
  logic [5:0]    pins_q, pins_d;

  // Result register.
  logic       res_vld_q;
  logic [5:0] res_pins_q;
  logic       res_busy_q;
  logic [1:0] res_cause_q;

  logic          accept, adv;
  logic          sense_load, hit;
  logic [1:0]    cause;
  logic [CW-1:0] cnt_inc;
  logic [19:0]   dur9;
  logic [39:0]   div_prod;
  logic [3:0]    llvl, rlvl;

  assign adv         = in_vld_q && (!res_vld_q || res_o.ready);
  assign cmd_i.ready = !in_vld_q || adv;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign cnt_inc  = pwm_cnt_q + 1'b1;
  assign dur9     = {4'd0, dur_q} + {1'b0, dur_q, 3'd0};
  assign div_prod = 40'(dur9) * 40'(tdmpd_pkg::DIV10_MUL);
  assign llvl     = tdmpd_pkg::level_of(lspd_q);
  assign rlvl     = tdmpd_pkg::level_of(rspd_q);

  tdmpd_sense #(
    .LINE_BITS (LINE_BITS)
  ) u_sense (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (sense_load),
    .switch_i     (sw_q),
    .left_line_i  (lline_q),
    .right_line_i (rline_q),
    .cfg_i        (cfg_i),
    .hit_o        (hit)
  );

  always_comb begin
    pwm_cnt_d  = pwm_cnt_q;
    lduty_d    = lduty_q;
    rduty_d    = rduty_q;
    ldir_d     = ldir_q;
    rdir_d     = rdir_q;
    tick_d     = tick_q;
    limit_d    = limit_q;
    moving_d   = moving_q;
    pins_d     = pins_q;
    sense_load = 1'b0;
    cause      = tdmpd_pkg::CAUSE_NONE;
    unique case (kind_q)
      tdmpd_pkg::KIND_PWM: begin
        pins_d[2:0] = tdmpd_pkg::chan_pins(pins_q[2:0], cnt_inc, lduty_q, ldir_q);
        pins_d[5:3] = tdmpd_pkg::chan_pins(pins_q[5:3], cnt_inc, rduty_q, rdir_q);
        pwm_cnt_d   = (cnt_inc >= PERIOD) ? '0 : cnt_inc;
        sense_load  = adv;
      end
      tdmpd_pkg::KIND_TIME: begin
        if (tick_q != '1) begin
          tick_d = tick_q + 1'b1;
        end
      end
      tdmpd_pkg::KIND_MOVE: begin
        ldir_d   = tdmpd_pkg::dir_of(lspd_q);
        rdir_d   = tdmpd_pkg::dir_of(rspd_q);
        lduty_d  = (llvl != '0) ? tdmpd_pkg::duty_lut(llvl) : lduty_q;
        rduty_d  = (rlvl != '0) ? tdmpd_pkg::duty_lut(rlvl) : rduty_q;
        tick_d   = DW'(1);
        limit_d  = div_prod[tdmpd_pkg::DIV10_SHIFT +: DW];
        moving_d = 1'b1;
      end
      default: ;
    endcase
    if (kind_q != tdmpd_pkg::KIND_NOP && moving_d) begin
      if (tick_d > limit_d) begin
        cause = tdmpd_pkg::CAUSE_TIME;
      end else if (!cfg_i.suppress_abort && hit) begin
        cause = tdmpd_pkg::CAUSE_SENSOR;
      end
      if (cause != tdmpd_pkg::CAUSE_NONE) begin
        moving_d = 1'b0;
        ldir_d   = tdmpd_pkg::DIR_STOP;
        rdir_d   = tdmpd_pkg::DIR_STOP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      pwm_cnt_q <= '0;
      lduty_q   <= '0;
      rduty_q   <= '0;
      ldir_q    <= tdmpd_pkg::DIR_STOP;
      rdir_q    <= tdmpd_pkg::DIR_STOP;
      tick_q    <= '0;
      limit_q   <= '0;
      moving_q  <= 1'b0;
      pins_q    <= '0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
      if (adv) begin
        pwm_cnt_q <= pwm_cnt_d;
        lduty_q   <= lduty_d;
        rduty_q   <= rduty_d;
        ldir_q    <= ldir_d;
        rdir_q    <= rdir_d;
        tick_q    <= tick_d;
        limit_q   <= limit_d;
        moving_q  <= moving_d;
        pins_q    <= pins_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= cmd_i.kind;
      sw_q    <= {cmd_i.right_bump, cmd_i.left_bump, cmd_i.right_ir, cmd_i.left_ir};
      lline_q <= cmd_i.left_adc;
      rline_q <= cmd_i.right_adc;
      dur_q   <= cmd_i.duration;
      lspd_q  <= cmd_i.left_speed;
      rspd_q  <= cmd_i.right_speed;
    end
    if (adv) begin
      res_pins_q  <= pins_d;
      res_busy_q  <= moving_d;
      res_cause_q <= cause;
    end
  end

  assign res_o.valid          = res_vld_q;
  assign res_o.left_enable    = res_pins_q[0];
  assign res_o.left_forward   = res_pins_q[1];
  assign res_o.left_backward  = res_pins_q[2];
  assign res_o.right_enable   = res_pins_q[3];
  assign res_o.right_forward  = res_pins_q[4];
  assign res_o.right_backward = res_pins_q[5];
  assign res_o.busy_res       = res_busy_q;
  assign res_o.end_cause      = res_cause_q;

endmodule

/* rtl/timed_dual_motor_pwm_drive.sv */
// Top level of the timed dual motor PWM drive: configuration registers and
// the drive core. Depends on tdmpd_pkg, the interfaces, tdmpd_cfg_regs and tdmpd_core.
//
//   Channel  Direction  Contents
//   cmd_i    in         PWM tick with sensor samples, time tick, move command or no-op
//   res_o    out        motor pins, busy flag and end cause, one per command
//   cfg_i    in         register index and write data
//
// Each command transaction passes through an input register, then the state
// update into the result register. One transaction is accepted in every cycle
// while results are taken. A stalled result holds the result register and the
// input register, and cmd_i.ready drops once both are full. Reset clears the
// drive state and sets the line latches to 700.
`timescale 1ns / 1ps

module timed_dual_motor_pwm_drive #(
  parameter int PWM_PERIOD = tdmpd_pkg::PWM_PERIOD_DEF,
  parameter int LINE_BITS  = tdmpd_pkg::LINE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tdmpd_cmd_if.sink   cmd_i,
  tdmpd_res_if.source res_o,
  tdmpd_cfg_if.sink   cfg_i
);

  tdmpd_pkg::cfg_t cfg;

  tdmpd_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tdmpd_core #(
    .PWM_PERIOD (PWM_PERIOD),
    .LINE_BITS  (LINE_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd_i),
    .res_o  (res_o)
  );

  a_end_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.end_cause != tdmpd_pkg::CAUSE_NONE |-> !res_o.busy_res)
    else $error("move reported as ended while still busy");

  a_left_dir_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.left_forward && res_o.left_backward))
    else $error("left bridge driven both ways");

  a_right_dir_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.right_forward && res_o.right_backward))
    else $error("right bridge driven both ways");

  a_stall_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ready |-> res_o.valid && !res_o.ready)
    else $error("command channel stalled without a pending result");

endmodule
